@@ src/md5hs_pkg.sv @@
// md5hs_pkg: shared types, constants and round tables for the md5 stream hasher
package md5hs_pkg;

    localparam int WORD_W    = 32;
    localparam int BLK_WORDS = 16;
    localparam int BLK_AW    = $clog2(BLK_WORDS);
    localparam int ROUNDS    = 64;
    localparam int ROUND_W   = $clog2(ROUNDS);
    localparam int LEN_W     = 64;
    localparam int CNT_W     = 3;

    // word slots that carry the low and high halves of the bit length
    localparam logic [BLK_AW-1:0] LEN_LO_SLOT = BLK_AW'(BLK_WORDS - 2);
    localparam logic [BLK_AW-1:0] LEN_HI_SLOT = BLK_AW'(BLK_WORDS - 1);

    localparam logic [WORD_W-1:0] PAD_BYTE = 32'h0000_0080;

    localparam logic [WORD_W-1:0] CHAIN_INIT [4] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476
    };

    localparam logic [WORD_W-1:0] SINE_TAB [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [CNT_W-1:0]  byte_count;
        logic              is_last;
    } t_md5hs_in;

    typedef struct packed {
        logic [2*WORD_W-1:0] digest_half;
        logic                half_index;
        logic                run_end;
    } t_md5hs_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT0,
        S_OUT1
    } t_md5hs_state;

    // message word index used by a given round
    function automatic logic [BLK_AW-1:0] msg_index(input logic [ROUND_W-1:0] r);
        logic [BLK_AW-1:0] lo;
        lo = r[BLK_AW-1:0];
        unique case (r[ROUND_W-1:ROUND_W-2])
            2'd0:    msg_index = lo;
            2'd1:    msg_index = BLK_AW'(lo * 4'd5 + 4'd1);
            2'd2:    msg_index = BLK_AW'(lo * 4'd3 + 4'd5);
            default: msg_index = BLK_AW'(lo * 4'd7);
        endcase
    endfunction

    function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] r);
        rot_amount = ROT_TAB[{r[ROUND_W-1:ROUND_W-2], r[1:0]}];
    endfunction

endpackage

@@ src/md5hs_ram.sv @@
// md5hs_ram: generic single-write, single-read ram with registered read data
module md5hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/md5_hash_stream.sv @@
// md5_hash_stream: streaming md5 digest, 16-word block buffer in ram, one round per cycle
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_in_req  (data_word, byte_count,
//          |           |                           |            is_last)
//  result  | out       | o_out_valid / i_out_ready | o_out_res (digest_half, half_index,
//          |           |                           |            run_end)
//
// a full message word is written into the block ram as it is accepted; the sixteenth word of a
// block also starts a compression (chain load, 64 rounds, chain add), during which no input
// is taken; the single round unit reads one message word a cycle
// the final request adds the padding words (up to 16 per block) plus one or
// two compressions, then the two digest halves, each held until taken
// synchronous active-low reset restores the initial chaining words and empties the buffer
// input is taken only in idle; result stalls simply hold the block in its output states
module md5_hash_stream
    import md5hs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_md5hs_in  i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_md5hs_out o_out_res
);

    // control state
    t_md5hs_state      r_state, n_state;
    logic [WORD_W-1:0] r_chain [4];
    logic [LEN_W-1:0]  r_bit_len;
    logic [BLK_AW-1:0] r_wcount;
    logic              r_last;      // message end seen, padding in progress
    logic              r_pad_done;  // 0x80 word already placed
    logic              r_lo_done;   // low length word already placed
    logic              r_fin;       // current compression is the final one

    // datapath registers
    logic [WORD_W-1:0]  r_a, r_b, r_c, r_d;
    logic [ROUND_W-1:0] r_round;
    logic [WORD_W-1:0]  r_pad_word;

    // ram ports
    logic              ram_wr_en;
    logic [BLK_AW-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [BLK_AW-1:0] ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    // input decode
    logic              in_acc;
    logic              in_full;
    logic [4:0]        in_shift;
    logic [WORD_W-1:0] in_pad_word;
    logic [LEN_W-1:0]  in_len_add;

    // padding word select
    logic [WORD_W-1:0] fill_data;
    logic              fill_lo;
    logic              fill_hi;

    // round logic
    logic [WORD_W-1:0] rnd_f;
    logic [WORD_W-1:0] rnd_sum;
    logic [4:0]        rnd_s;
    logic [5:0]        rnd_sr;
    logic [WORD_W-1:0] rnd_rot;

    md5hs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLK_WORDS)
    ) u_blk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // a word that is not last, or that has four or more bytes, goes in whole
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_full     = !i_in_req.is_last || i_in_req.byte_count[2];
    assign in_shift    = {i_in_req.byte_count[1:0], 3'b000};
    assign in_pad_word = in_full ? PAD_BYTE
                       : ((i_in_req.data_word & ~({WORD_W{1'b1}} << in_shift))
                          | (PAD_BYTE << in_shift));
    assign in_len_add  = in_full ? LEN_W'(WORD_W) : LEN_W'(in_shift);

    // padding sequence: 0x80 word, zeros up to slot 14, then the bit length
    assign fill_lo = r_pad_done && (r_wcount == LEN_LO_SLOT);
    assign fill_hi = r_pad_done && (r_wcount == LEN_HI_SLOT) && r_lo_done;

    always_comb begin
        if (!r_pad_done) begin
            fill_data = r_pad_word;
        end else if (fill_lo) begin
            fill_data = r_bit_len[WORD_W-1:0];
        end else if (fill_hi) begin
            fill_data = r_bit_len[LEN_W-1:WORD_W];
        end else begin
            fill_data = '0;
        end
    end

    // one md5 round, message word comes from the ram read issued last cycle
    always_comb begin
        unique case (r_round[ROUND_W-1:ROUND_W-2])
            2'd0:    rnd_f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    rnd_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    rnd_f = r_b ^ r_c ^ r_d;
            default: rnd_f = r_c ^ (r_b | ~r_d);
        endcase
    end

    assign rnd_sum = r_a + rnd_f + SINE_TAB[r_round] + ram_rd_data;
    assign rnd_s   = rot_amount(r_round);
    assign rnd_sr  = 6'(WORD_W) - {1'b0, rnd_s};
    assign rnd_rot = (rnd_sum << rnd_s) | (rnd_sum >> rnd_sr);

    // sequencer: next state, ram access and handshakes
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wcount;
        ram_wr_data = i_in_req.data_word;
        ram_rd_addr = msg_index(r_round + 1'b1);

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    ram_wr_en = in_full;
                    if (in_full && (r_wcount == LEN_HI_SLOT)) begin
                        n_state = S_LOAD;
                    end else if (i_in_req.is_last) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = fill_data;
                if (r_wcount == LEN_HI_SLOT) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                ram_rd_addr = msg_index('0);
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                if (r_round == ROUND_W'(ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_fin) begin
                    n_state = S_OUT0;
                end else if (r_last) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT0: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_OUT1;
                end
            end
            S_OUT1: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // digest halves, little-endian byte order within each chaining word
    always_comb begin
        o_out_res.half_index = (r_state == S_OUT1);
        o_out_res.run_end    = (r_state == S_OUT1);
        if (r_state == S_OUT1) begin
            o_out_res.digest_half = {r_chain[3], r_chain[2]};
        end else begin
            o_out_res.digest_half = {r_chain[1], r_chain[0]};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_chain    <= CHAIN_INIT;
            r_bit_len  <= '0;
            r_wcount   <= '0;
            r_last     <= 1'b0;
            r_pad_done <= 1'b0;
            r_lo_done  <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            r_state <= n_state;

            // write pointer wraps to zero as the sixteenth word lands
            if (ram_wr_en) begin
                r_wcount <= r_wcount + 1'b1;
            end

            if (in_acc) begin
                r_bit_len  <= r_bit_len + in_len_add;
                r_last     <= i_in_req.is_last;
                r_pad_done <= 1'b0;
            end

            if (r_state == S_FILL) begin
                if (!r_pad_done) begin
                    r_pad_done <= 1'b1;
                end
                if (fill_lo) begin
                    r_lo_done <= 1'b1;
                end
                if (fill_hi) begin
                    r_fin <= 1'b1;
                end
            end

            if (r_state == S_ADD) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end

            // second half taken: start a fresh message
            if ((r_state == S_OUT1) && i_out_ready) begin
                r_chain   <= CHAIN_INIT;
                r_bit_len <= '0;
                r_last    <= 1'b0;
                r_lo_done <= 1'b0;
                r_fin     <= 1'b0;
            end
        end
    end

    // working registers and round counter
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pad_word <= in_pad_word;
        end
        if (r_state == S_LOAD) begin
            r_a     <= r_chain[0];
            r_b     <= r_chain[1];
            r_c     <= r_chain[2];
            r_d     <= r_chain[3];
            r_round <= '0;
        end else if (r_state == S_ROUND) begin
            r_a     <= r_d;
            r_d     <= r_c;
            r_c     <= r_b;
            r_b     <= r_b + rnd_rot;
            r_round <= r_round + 1'b1;
        end
    end

endmodule
